/* hw/rtl/tabexp_pkg.sv */
package tabexp_pkg;

    localparam int MAX_TAB_WIDTH = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int EFF_MAX_INT   = (MAX_TAB_WIDTH < MAX_RESULTS) ? MAX_TAB_WIDTH : MAX_RESULTS;
    localparam logic [4:0] EFF_MAX = 5'(EFF_MAX_INT);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] COLUMN_MAX = 16'hFFFF;

    localparam logic [4:0]  TAB_WIDTH_RST = 5'd8;
    localparam logic [15:0] MARGIN_RST    = 16'd0;

    localparam logic REG_TAB_WIDTH    = 1'b0;
    localparam logic REG_MARGIN_LIMIT = 1'b1;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic take;        // request accepted this cycle
        logic load_count;  // remainder ready: set space count, advance column
        logic emit;        // push one space into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic tab_go;      // current request is a tab that expands
        logic mod_done;
        logic last_space;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/tabexp_mod.sv */
module tabexp_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [4:0]  i_divisor,
    output logic        o_done,
    output logic [3:0]  o_rem
);
    import tabexp_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_div, n_div;
    logic [3:0]  r_rem, n_rem;
    logic [4:0]  r_dsr, n_dsr;
    logic [4:0]  w_trial;

    // restoring remainder, one dividend bit per cycle
    assign w_trial = {r_rem, r_div[15]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd15;
            n_div  = i_dividend;
            n_rem  = 4'd0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_div = {r_div[14:0], 1'b0};
            if (w_trial >= r_dsr) begin
                n_rem = 4'(w_trial - r_dsr);
            end else begin
                n_rem = w_trial[3:0];
            end
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/tabexp_dp.sv */
module tabexp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_func,
    input  logic [7:0]         i_in_byte,
    input  logic               i_out_ready,
    input  tabexp_pkg::t_cmd   i_cmd,
    output tabexp_pkg::t_status o_status,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last_of_run,
    output logic               o_text_done
);
    import tabexp_pkg::*;

    logic [4:0]  r_tab_width, n_tab_width;
    logic [15:0] r_margin, n_margin;
    logic [15:0] r_column, n_column;
    logic        r_last_nl, n_last_nl;
    logic [4:0]  r_spaces, n_spaces;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;
    logic        r_out_done, n_out_done;

    logic [4:0]  w_eff;
    logic        w_margin_ok;
    logic        w_is_tab;
    logic        w_mod_start;
    logic        w_mod_done;
    logic [3:0]  w_rem;
    logic [4:0]  w_count;
    logic [16:0] w_col_sum;
    logic [15:0] w_col_inc;

    always_comb begin
        if (r_tab_width == 5'd0) begin
            w_eff = 5'd1;
        end else if (r_tab_width > EFF_MAX) begin
            w_eff = EFF_MAX;
        end else begin
            w_eff = r_tab_width;
        end
    end

    assign w_margin_ok = (r_margin == 16'd0) || (r_column < r_margin);
    assign w_is_tab    = (i_func == FUNC_BYTE) && (i_in_byte == CH_TAB);
    assign w_mod_start = i_cmd.take && w_is_tab && w_margin_ok;
    assign w_count     = w_eff - {1'b0, w_rem};

    // saturating column advance; the addend is 1 for a byte or the space count for a tab
    assign w_col_inc = i_cmd.load_count ? {11'd0, w_count} : 16'd1;
    assign w_col_sum = {1'b0, r_column} + {1'b0, w_col_inc};

    tabexp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_column),
        .i_divisor  (w_eff),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_tab_width = r_tab_width;
        n_margin    = r_margin;
        n_column    = r_column;
        n_last_nl   = r_last_nl;
        n_spaces    = r_spaces;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TAB_WIDTH:    n_tab_width = i_cfg_data[4:0];
                REG_MARGIN_LIMIT: n_margin    = i_cfg_data;
                default:          ;
            endcase
        end

        if (i_cmd.take) begin
            if (i_func == FUNC_END) begin
                if (!r_last_nl) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = CH_NL;
                    n_out_last  = 1'b1;
                    n_out_done  = 1'b1;
                end
                n_column  = 16'd0;
                n_last_nl = 1'b0;
            end else if (i_in_byte == CH_NL) begin
                n_out_valid = 1'b1;
                n_out_byte  = CH_NL;
                n_out_last  = 1'b1;
                n_out_done  = 1'b0;
                n_column    = 16'd0;
                n_last_nl   = 1'b1;
            end else if (i_in_byte != CH_CR && i_in_byte != CH_TAB) begin
                n_out_valid = 1'b1;
                n_out_byte  = i_in_byte;
                n_out_last  = 1'b1;
                n_out_done  = 1'b0;
                n_column    = w_col_sum[16] ? COLUMN_MAX : w_col_sum[15:0];
                n_last_nl   = 1'b0;
            end
        end

        if (i_cmd.load_count) begin
            n_spaces  = w_count;
            n_column  = w_col_sum[16] ? COLUMN_MAX : w_col_sum[15:0];
            n_last_nl = 1'b0;
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = CH_SPACE;
            n_out_last  = (r_spaces == 5'd1);
            n_out_done  = 1'b0;
            n_spaces    = r_spaces - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= TAB_WIDTH_RST;
            r_margin    <= MARGIN_RST;
            r_column    <= 16'd0;
            r_last_nl   <= 1'b0;
            r_spaces    <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_tab_width <= n_tab_width;
            r_margin    <= n_margin;
            r_column    <= n_column;
            r_last_nl   <= n_last_nl;
            r_spaces    <= n_spaces;
            r_out_valid <= n_out_valid;
        end
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    assign o_status.tab_go     = w_is_tab && w_margin_ok;
    assign o_status.mod_done   = w_mod_done;
    assign o_status.last_space = (r_spaces == 5'd1);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_text_done   = r_out_done;

endmodule

/* hw/rtl/tabexp_ctrl.sv */
module tabexp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tabexp_pkg::t_status i_status,
    output tabexp_pkg::t_cmd    o_cmd
);
    import tabexp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       w_take;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign w_take     = o_in_ready && i_in_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd.take       = 1'b0;
        o_cmd.load_count = 1'b0;
        o_cmd.emit       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = w_take;
                if (w_take && i_status.tab_go) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_status.mod_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_count = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_space) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/tab_expand_text_normalizer_core.sv */
// Tab-expanding text normalizer: one text byte (or an end-of-text mark) per
// request in, normalized bytes out. Carriage returns are dropped, a tab becomes
// spaces up to the next tab stop while the column is below the margin (margin 0
// means no limit), and end of text adds a closing newline when needed and clears
// the column. Ordinary bytes, newlines, carriage returns and end of text are
// accepted back to back while the output is free. An expanding tab is accepted,
// then the bit-serial column-modulo-tab-width unit runs, its result is picked
// up, the space count is loaded and the spaces are emitted in turn; no new
// request is taken until the last space is out. Output stalls hold both.
// Write the configuration registers only while the block is idle.
module tab_expand_text_normalizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_text_done
);
    import tabexp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tabexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tabexp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_in_byte     (i_in_byte),
        .i_out_ready   (i_out_ready),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import tabexp_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       text_done;
    } t_norm_result;

    // Tracks column and newline state the same way the block should, and
    // keeps the bytes still owed by the block in request order.
    class t_text_norm_scoreboard;
        t_norm_result owed_q[$];
        logic [4:0]   tab_width_reg;
        logic [15:0]  margin_reg;
        int unsigned  column;
        bit           ended_on_newline;
        int           failures;

        function new();
            tab_width_reg = TAB_WIDTH_RST;
            margin_reg    = MARGIN_RST;
            failures      = 0;
            clear_line();
        endfunction

        function void clear_line();
            column           = 0;
            ended_on_newline = 1'b0;
        endfunction

        function void write_register(logic index, logic [15:0] data);
            if (index == REG_TAB_WIDTH) begin
                tab_width_reg = data[4:0];
            end else begin
                margin_reg = data;
            end
        endfunction

        function void owe(logic [7:0] b, logic last, logic done);
            t_norm_result r;
            r.out_byte    = b;
            r.last_of_run = last;
            r.text_done   = done;
            owed_q.push_back(r);
        endfunction

        function void advance_column(int unsigned n);
            column = (column + n > COLUMN_MAX) ? COLUMN_MAX : column + n;
        endfunction

        function int unsigned tab_stop_width();
            if (tab_width_reg == 0)
                return 1;
            if (tab_width_reg > EFF_MAX)
                return EFF_MAX;
            return tab_width_reg;
        endfunction

        // Expected bytes for one accepted request
        function void note_request(logic func, logic [7:0] in_byte);
            int unsigned w;
            int unsigned n;
            w = tab_stop_width();
            if (func == FUNC_END) begin
                if (!ended_on_newline)
                    owe(CH_NL, 1'b1, 1'b1);
                clear_line();
            end else if (in_byte == CH_CR) begin
                // dropped, state untouched
            end else if (in_byte == CH_TAB) begin
                if (margin_reg == 0 || column < margin_reg) begin
                    n = w - (column % w);
                    for (int unsigned i = 0; i < n; i++)
                        owe(CH_SPACE, (i + 1 == n), 1'b0);
                    advance_column(n);
                    ended_on_newline = 1'b0;
                end
            end else if (in_byte == CH_NL) begin
                owe(CH_NL, 1'b1, 1'b0);
                column           = 0;
                ended_on_newline = 1'b1;
            end else begin
                owe(in_byte, 1'b1, 1'b0);
                advance_column(1);
                ended_on_newline = 1'b0;
            end
        endfunction

        function void report(string what, logic [7:0] want, logic [7:0] got);
            failures++;
            $display("%0t ns: %s mismatch: expected %02h, actual %02h",
                     $time, what, want, got);
        endfunction

        function void check_result(logic [7:0] b, logic last, logic done);
            t_norm_result want;
            if (owed_q.size() == 0) begin
                failures++;
                $display("%0t ns: unexpected result: expected none, actual %02h last=%0b done=%0b",
                         $time, b, last, done);
                return;
            end
            want = owed_q.pop_front();
            if (want.out_byte !== b)
                report("out_byte", want.out_byte, b);
            if (want.last_of_run !== last)
                report("last_of_run", 8'(want.last_of_run), 8'(last));
            if (want.text_done !== done)
                report("text_done", 8'(want.text_done), 8'(done));
        endfunction

        function int pending_count();
            return owed_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = REG_TAB_WIDTH;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        i_func      = FUNC_BYTE;
    logic [7:0]  i_in_byte   = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic        o_text_done;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_off_cycles = 0;

    t_text_norm_scoreboard sb;

    tab_expand_text_normalizer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Request first, then result, so a same-edge pass-through still lines up
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready === 1'b1)
                sb.note_request(i_func, i_in_byte);
            if (o_out_valid === 1'b1 && i_out_ready)
                sb.check_result(o_out_byte, o_last_of_run, o_text_done);
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic func, input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic send_char(input logic [7:0] b);
        send_request(FUNC_BYTE, b);
    endtask

    task automatic send_end();
        send_request(FUNC_END, 8'($urandom_range(255)));
    endtask

    // Drain, then allow for a tab still in its modulo pass
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        sb.write_register(index, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_text(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 4)
                send_end();
            else if (r < 20)
                send_char(CH_TAB);
            else if (r < 28)
                send_char(CH_NL);
            else if (r < 32)
                send_char(CH_CR);
            else
                send_char(8'($urandom_range(255)));
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 57;

        // reset settings: width 8, no margin
        send_end();                 // empty text still closes with a newline
        send_char(8'h00);
        send_char(CH_TAB);
        send_char(8'hFF);
        send_char(CH_CR);
        send_char(CH_NL);
        send_end();                 // already on a newline: nothing
        send_char(CH_CR);
        send_end();                 // only dropped bytes
        wait_idle();

        write_register(REG_TAB_WIDTH, 16'd0);   // behaves as width 1
        send_char(CH_TAB);
        send_char("a");
        send_char(CH_TAB);
        wait_idle();

        write_register(REG_TAB_WIDTH, 16'hFFFF); // 31, clamps to 16
        send_char(CH_TAB);
        send_char(CH_NL);
        send_char(CH_TAB);          // full sixteen spaces
        wait_idle();

        write_register(REG_TAB_WIDTH, 16'd17);
        send_char(CH_TAB);
        wait_idle();

        write_register(REG_TAB_WIDTH, 16'd4);
        write_register(REG_MARGIN_LIMIT, 16'd3);
        send_char(CH_NL);
        send_char("a");
        send_char("b");
        send_char(CH_TAB);          // column 2, below margin
        send_char(CH_TAB);          // column 4, past margin: dropped
        send_end();
        wait_idle();

        write_register(REG_TAB_WIDTH, 16'd1);
        write_register(REG_MARGIN_LIMIT, 16'd0);
        send_random_text(100);
        wait_idle();

        send_idle_pct = 57;
        recv_idle_pct = 10;
        write_register(REG_TAB_WIDTH, 16'($urandom_range(2, 15)));
        write_register(REG_MARGIN_LIMIT, 16'($urandom_range(8, 40)));
        send_random_text(100);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(REG_TAB_WIDTH, 16'd16);
        write_register(REG_MARGIN_LIMIT, 16'd24);
        hold_off_cycles = 300;      // output backs up, input must stall
        send_random_text(100);
        wait_idle();

        // widest margin: tabs still expand
        write_register(REG_TAB_WIDTH, 16'd3);
        write_register(REG_MARGIN_LIMIT, 16'hFFFF);
        send_char("q");
        send_char(CH_TAB);          // column 1 to 3
        send_char(CH_NL);
        send_end();
        wait_idle();

        if (sb.failures == 0 && sb.pending_count() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
